// ----- src/dccf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package dccf_pkg;

  localparam int MAX_DEVICES = 63;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  // Length, device, two register bytes and two CRC bytes, plus one for the length code.
  localparam logic [8:0] FRAME_FIXED_BYTES = 9'd7;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_LENGTH     = 3'd1,
    ST_REGISTER   = 3'd2,
    ST_CRC        = 3'd3,
    ST_DEVICE     = 3'd4,
    ST_RANGE      = 3'd5,
    ST_DUPLICATE  = 3'd6
  } frame_status_t;

  typedef enum logic [2:0] {
    REG_PAYLOAD_LEN   = 3'd0,
    REG_EXPECTED_REG  = 3'd1,
    REG_SINGLE_MODE   = 3'd2,
    REG_EXPECTED_DEV  = 3'd3,
    REG_BOARD_COUNT   = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [7:0]  payload_len_code;
    logic [15:0] expected_register;
    logic        single_device_mode;
    logic [5:0]  expected_device;
    logic [5:0]  board_count;
  } cfg_t;

  typedef struct packed {
    logic          valid;
    frame_status_t status;
    logic [7:0]    device;
  } result_t;

  typedef logic [15:0] crc_table_t [256];

  // Byte-wise table for the reflected polynomial, built at elaboration.
  function automatic crc_table_t build_crc_table();
    crc_table_t t;
    logic [15:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 16'(i);
      for (int k = 0; k < 8; k++) begin
        if (c[0]) begin
          c = (c >> 1) ^ CRC_POLY;
        end else begin
          c = c >> 1;
        end
      end
      t[i] = c;
    end
    return t;
  endfunction

  localparam crc_table_t CRC_TABLE = build_crc_table();

endpackage
`default_nettype wire

// ----- src/dccf_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dccf_cfg (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output dccf_pkg::cfg_t    cfg
);
  import dccf_pkg::*;

  logic       wr_en;
  reg_index_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.payload_len_code   <= 8'd0;
      cfg.expected_register  <= 16'd0;
      cfg.single_device_mode <= 1'b0;
      cfg.expected_device    <= 6'd0;
      cfg.board_count        <= 6'd1;
    end else if (wr_en) begin
      case (idx)
        REG_PAYLOAD_LEN:  cfg.payload_len_code   <= pwdata[7:0];
        REG_EXPECTED_REG: cfg.expected_register  <= pwdata[15:0];
        REG_SINGLE_MODE:  cfg.single_device_mode <= pwdata[0];
        REG_EXPECTED_DEV: cfg.expected_device    <= pwdata[5:0];
        REG_BOARD_COUNT:  cfg.board_count        <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PAYLOAD_LEN:  prdata = {24'd0, cfg.payload_len_code};
      REG_EXPECTED_REG: prdata = {16'd0, cfg.expected_register};
      REG_SINGLE_MODE:  prdata = {31'd0, cfg.single_device_mode};
      REG_EXPECTED_DEV: prdata = {26'd0, cfg.expected_device};
      REG_BOARD_COUNT:  prdata = {26'd0, cfg.board_count};
      default:          prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ----- src/dccf_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dccf_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      rx_byte,
  input  wire logic            start_response,
  input  wire dccf_pkg::cfg_t  cfg,
  output dccf_pkg::result_t    result
);
  import dccf_pkg::*;

  logic [15:0] crc_reg;
  logic [8:0]  byte_position;
  logic        length_bad;
  logic        register_bad;
  logic [7:0]  captured_device;
  logic [63:0] seen_map;

  logic [15:0] crc_cur, crc_next;
  logic [8:0]  pos_cur, pos_next;
  logic        len_cur, len_next;
  logic        reg_cur, reg_next;
  logic [7:0]  dev_cur, dev_next;
  logic [63:0] seen_cur, seen_next;
  logic [8:0]  frame_size;
  logic        frame_done;
  logic        mark_seen;
  frame_status_t status;

  always_comb begin
    // A response start drops any partial frame and clears the seen map.
    if (start_response) begin
      crc_cur  = CRC_INIT;
      pos_cur  = 9'd0;
      len_cur  = 1'b0;
      reg_cur  = 1'b0;
      dev_cur  = 8'd0;
      seen_cur = 64'd0;
    end else begin
      crc_cur  = crc_reg;
      pos_cur  = byte_position;
      len_cur  = length_bad;
      reg_cur  = register_bad;
      dev_cur  = captured_device;
      seen_cur = seen_map;
    end

    len_next = len_cur;
    reg_next = reg_cur;
    dev_next = dev_cur;
    case (pos_cur)
      9'd0: len_next = (rx_byte != cfg.payload_len_code);
      9'd1: dev_next = rx_byte;
      9'd2: reg_next = reg_cur | (rx_byte != cfg.expected_register[15:8]);
      9'd3: reg_next = reg_cur | (rx_byte != cfg.expected_register[7:0]);
      default: ;
    endcase

    crc_next   = (crc_cur >> 8) ^ CRC_TABLE[crc_cur[7:0] ^ rx_byte];
    pos_next   = pos_cur + 9'd1;
    frame_size = {1'b0, cfg.payload_len_code} + FRAME_FIXED_BYTES;
    frame_done = (pos_next >= frame_size);

    mark_seen = 1'b0;
    if (len_next) begin
      status = ST_LENGTH;
    end else if (reg_next) begin
      status = ST_REGISTER;
    end else if (crc_next != 16'd0) begin
      status = ST_CRC;
    end else if (cfg.single_device_mode) begin
      status = (dev_next != {2'b00, cfg.expected_device}) ? ST_DEVICE : ST_OK;
    end else if (dev_next == 8'd0 || dev_next > {2'b00, cfg.board_count}) begin
      status = ST_RANGE;
    end else if (seen_cur[dev_next[5:0]]) begin
      status = ST_DUPLICATE;
    end else begin
      status    = ST_OK;
      mark_seen = 1'b1;
    end

    seen_next = seen_cur;
    if (frame_done && mark_seen) begin
      seen_next[dev_next[5:0]] = 1'b1;
    end
  end

  assign result.valid  = accept & frame_done;
  assign result.status = status;
  assign result.device = dev_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg         <= CRC_INIT;
      byte_position   <= 9'd0;
      length_bad      <= 1'b0;
      register_bad    <= 1'b0;
      captured_device <= 8'd0;
      seen_map        <= 64'd0;
    end else if (accept) begin
      seen_map <= seen_next;
      if (frame_done) begin
        crc_reg         <= CRC_INIT;
        byte_position   <= 9'd0;
        length_bad      <= 1'b0;
        register_bad    <= 1'b0;
        captured_device <= 8'd0;
      end else begin
        crc_reg         <= crc_next;
        byte_position   <= pos_next;
        length_bad      <= len_next;
        register_bad    <= reg_next;
        captured_device <= dev_next;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/dccf_skid.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dccf_skid (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dccf_pkg::result_t  result,
  output logic                    in_ready,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [15:0]             m_tdata
);
  import dccf_pkg::*;

  logic        out_valid;
  logic [10:0] out_data;
  logic        skid_valid;
  logic [10:0] skid_data;
  logic        out_free;
  logic [10:0] push_data;

  assign push_data = {result.device, result.status};
  assign out_free  = ~out_valid | m_tready;
  assign in_ready  = ~skid_valid;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {5'd0, out_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_free) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (result.valid) begin
      if (out_free) begin
        out_valid <= 1'b1;
        out_data  <= push_data;
      end else begin
        skid_valid <= 1'b1;
        skid_data  <= push_data;
      end
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- src/daisy_chain_response_frame_checker.sv -----
// Checks CRC-16/MODBUS framed responses that arrive one byte per item.
// Input channel s_*: tdata carries the received byte, tuser[0] marks the
// first byte of a new response (drops any partial frame, clears the map of
// stack addresses already seen). Each frame is length, device, register
// high, register low, payload, CRC low, CRC high.
// Output channel m_*: one item per finished frame with the status code and
// the device address byte of that frame.
// Throughput is one byte per cycle while s_tready is high: the byte CRC is
// a 256-entry table lookup and all field compares sit between the input
// handshake and the result register. The result of a frame is registered
// once its last byte is accepted, in the output or the skid register.
// If the receiver stalls, one further result is held in a skid register;
// s_tready drops only while both the output and skid registers are full.
// Reset (rst, synchronous) empties the output, restores the register
// defaults and starts a fresh frame with an empty seen map.
// Registers on the APB port lie at 4*index; writes belong to idle periods.
`timescale 1ns / 1ps
`default_nettype none
module daisy_chain_response_frame_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]  s_tuser,   // [0] start_response
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [2:0] frame_status, [10:3] frame_device
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import dccf_pkg::*;

  cfg_t    cfg;
  result_t result;
  logic    accept;

  assign accept = s_tvalid & s_tready;

  dccf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dccf_core u_core (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .rx_byte        (s_tdata),
    .start_response (s_tuser[0]),
    .cfg            (cfg),
    .result         (result)
  );

  dccf_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .result   (result),
    .in_ready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

// ----- src/dccf_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dccf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);
  import dccf_pkg::*;

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn while stalled");

  // Input back-pressure only comes from a full output register.
  a_ready_implies_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

  // No status code beyond duplicate, and the padding bits stay zero.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] != 3'd7) && (m_tdata[15:11] == 5'd0))
    else $error("bad result encoding");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("output not empty after reset");

endmodule

bind daisy_chain_response_frame_checker dccf_checker u_dccf_checker (.*);
`default_nettype wire
